FILE: rtl/core/sobel_pkg.sv
package sobel_pkg;

    // sample and arithmetic widths
    localparam int SAMPLE_BITS = 8;
    localparam int CHANNELS    = 3;
    localparam int GRAD_W      = SAMPLE_BITS + 3;
    localparam int SQ_W        = 2 * GRAD_W;
    localparam int ROOT_W      = GRAD_W;
    localparam int ROOT_STEPS  = ROOT_W;
    localparam int STEP_W      = $clog2(ROOT_STEPS);
    localparam int MIX_W       = 18;
    localparam int GRAY_W      = 11;

    // first trial bit of the square root, highest power of four in range
    localparam logic [SQ_W-1:0] ROOT_START = {2'b01, {(SQ_W-2){1'b0}}};

    // channel weights of the gray mix
    localparam logic [MIX_W-1:0] WEIGHT_RED   = MIX_W'(30);
    localparam logic [MIX_W-1:0] WEIGHT_GREEN = MIX_W'(59);
    localparam logic [MIX_W-1:0] WEIGHT_BLUE  = MIX_W'(11);

    // divide by 100 as multiply by ceil(2^25/100) and shift
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 25;
    localparam int PROD_W      = MIX_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = 19'd335545;

    // configuration registers
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0]  HEIGHT_RESET = 11'd480;

    typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] pixel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_MIX,
        ST_SCALE,
        ST_QUOT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic take_pixel;
        logic shift;
        logic zero;
        logic grad;
        logic square;
        logic root_step;
        logic mix;
        logic scale;
        logic quot;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic input_done;
        logic due;
        logic border;
        logic root_last;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: rtl/core/sobel_ctrl.sv
module sobel_ctrl import sobel_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  logic    s_flush,
    output logic    s_ready,
    output dp_cmd_t cmd_o,
    input  dp_sts_t sts_i
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (sts_i.input_done) begin
                        cmd_o.zero = 1'b1;
                        state_next = ST_OUT;
                    end else if (!s_flush) begin
                        cmd_o.take_pixel = 1'b1;
                        state_next       = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                cmd_o.shift = 1'b1;
                if (!sts_i.due) begin
                    state_next = ST_IDLE;
                end else if (sts_i.border) begin
                    cmd_o.zero = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_GRAD;
                end
            end
            ST_GRAD: begin
                cmd_o.grad = 1'b1;
                state_next = ST_SQUARE;
            end
            ST_SQUARE: begin
                cmd_o.square = 1'b1;
                state_next   = ST_ROOT;
            end
            ST_ROOT: begin
                cmd_o.root_step = 1'b1;
                if (sts_i.root_last) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                cmd_o.mix  = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                cmd_o.scale = 1'b1;
                state_next  = ST_QUOT;
            end
            ST_QUOT: begin
                cmd_o.quot = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts_i.out_free) begin
                    cmd_o.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a result is only loaded into a free output register
    assert property (@(posedge aclk) disable iff (!aresetn) cmd_o.emit |-> sts_i.out_free)
        else $error("result loaded while output register busy");

    // window shift always follows a pixel transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT |-> $past(state_reg) == ST_IDLE)
        else $error("window shift without pixel");

endmodule

FILE: rtl/core/sobel_dp.sv
module sobel_dp import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dp_cmd_t                cmd_i,
    output dp_sts_t                sts_o,
    input  logic [SAMPLE_BITS-1:0] s_red,
    input  logic [SAMPLE_BITS-1:0] s_green,
    input  logic [SAMPLE_BITS-1:0] s_blue,
    input  logic                   cfg_wr,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic [GRAY_W-1:0]      m_gray,
    output logic                   m_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_DATA_W-1:0] width_cfg_reg;
    logic [CFG_DATA_W-1:0] height_cfg_reg;
    logic [WW-1:0]         w_eff;
    logic [RW-1:0]         h_eff;

    logic [CW-1:0] in_col_reg;
    logic [RW-1:0] in_row_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;

    logic in_col_last;
    logic out_col_last;
    logic out_row_last;
    logic last_pos;
    logic cfg_hit;
    logic restart;

    pixel_t px;
    pixel_t px_reg;
    pixel_t rd0_reg;
    pixel_t rd1_reg;
    pixel_t bank0 [MAX_WIDTH];
    pixel_t bank1 [MAX_WIDTH];
    logic   par_reg;
    logic   due_reg;

    pixel_t win_reg [9];

    logic signed [GRAD_W-1:0] gx_reg [CHANNELS];
    logic signed [GRAD_W-1:0] gy_reg [CHANNELS];
    logic        [GRAD_W-1:0] gx_c   [CHANNELS];
    logic        [GRAD_W-1:0] gy_c   [CHANNELS];
    logic signed [SQ_W-1:0]   sqx_c  [CHANNELS];
    logic signed [SQ_W-1:0]   sqy_c  [CHANNELS];

    logic [SQ_W-1:0]   rem_reg [CHANNELS];
    logic [SQ_W-1:0]   res_reg [CHANNELS];
    logic [SQ_W-1:0]   bit_reg;
    logic [STEP_W-1:0] step_reg;

    logic [MIX_W-1:0]  mix_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [GRAY_W-1:0] result_reg;

    logic              m_valid_reg;
    logic [GRAY_W-1:0] m_gray_reg;
    logic              m_last_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_cfg_reg <= cfg_data;
            end
            if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_cfg_reg <= cfg_data;
            end
        end
    end

    // size clamped to 1..max
    always_comb begin
        if (width_cfg_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_cfg_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_cfg_reg);
        end
        if (height_cfg_reg == '0) begin
            h_eff = RW'(1);
        end else if (32'(height_cfg_reg) > MAX_HEIGHT) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(height_cfg_reg);
        end
    end

    // positions; a real register write or the last emit restarts the frame
    assign in_col_last  = WW'(in_col_reg) == (w_eff - WW'(1));
    assign out_col_last = WW'(out_col_reg) == (w_eff - WW'(1));
    assign out_row_last = out_row_reg == (h_eff - RW'(1));
    assign last_pos     = out_col_last && out_row_last;
    assign cfg_hit      = cfg_wr && ((cfg_index == REG_IMAGE_WIDTH) ||
                                     (cfg_index == REG_IMAGE_HEIGHT));
    assign restart      = cfg_hit || (cmd_i.emit && last_pos);

    // input and output position counters
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else begin
            if (cmd_i.take_pixel) begin
                if (in_col_last) begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + RW'(1);
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (cmd_i.emit) begin
                if (out_col_last) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + RW'(1);
                end else begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    assign px = {s_blue, s_green, s_red};

    // line stores, read before write at the current column
    always_ff @(posedge aclk) begin
        if (cmd_i.take_pixel) begin
            rd0_reg <= bank0[in_col_reg];
            rd1_reg <= bank1[in_col_reg];
            if (!in_row_reg[0]) begin
                bank0[in_col_reg] <= px;
            end else begin
                bank1[in_col_reg] <= px;
            end
        end
    end

    // pixel capture and whether a result is due
    always_ff @(posedge aclk) begin
        if (cmd_i.take_pixel) begin
            px_reg  <= px;
            par_reg <= in_row_reg[0];
            due_reg <= !((in_row_reg == RW'(0)) ||
                         (in_row_reg == RW'(1) && in_col_reg == CW'(0)));
        end
    end

    // 3x3 window, rows from two lines back, one line back and current
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd_i.shift) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= par_reg ? rd1_reg : rd0_reg;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= par_reg ? rd0_reg : rd1_reg;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= px_reg;
        end
    end

    // sobel gradients and their squares per channel
    always_comb begin
        for (int k = 0; k < CHANNELS; k++) begin
            gx_c[k] = (GRAD_W'(win_reg[0][k]) + (GRAD_W'(win_reg[3][k]) << 1) +
                       GRAD_W'(win_reg[6][k])) -
                      (GRAD_W'(win_reg[2][k]) + (GRAD_W'(win_reg[5][k]) << 1) +
                       GRAD_W'(win_reg[8][k]));
            gy_c[k] = (GRAD_W'(win_reg[0][k]) + (GRAD_W'(win_reg[1][k]) << 1) +
                       GRAD_W'(win_reg[2][k])) -
                      (GRAD_W'(win_reg[6][k]) + (GRAD_W'(win_reg[7][k]) << 1) +
                       GRAD_W'(win_reg[8][k]));
            sqx_c[k] = gx_reg[k] * gx_reg[k];
            sqy_c[k] = gy_reg[k] * gy_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.grad) begin
            for (int k = 0; k < CHANNELS; k++) begin
                gx_reg[k] <= signed'(gx_c[k]);
                gy_reg[k] <= signed'(gy_c[k]);
            end
        end
    end

    // integer square roots, one result bit per step on each channel
    always_ff @(posedge aclk) begin
        if (cmd_i.square) begin
            for (int k = 0; k < CHANNELS; k++) begin
                rem_reg[k] <= unsigned'(sqx_c[k]) + unsigned'(sqy_c[k]);
                res_reg[k] <= '0;
            end
            bit_reg  <= ROOT_START;
            step_reg <= '0;
        end else if (cmd_i.root_step) begin
            for (int k = 0; k < CHANNELS; k++) begin
                if (rem_reg[k] >= res_reg[k] + bit_reg) begin
                    rem_reg[k] <= rem_reg[k] - (res_reg[k] + bit_reg);
                    res_reg[k] <= (res_reg[k] >> 1) + bit_reg;
                end else begin
                    res_reg[k] <= res_reg[k] >> 1;
                end
            end
            bit_reg  <= bit_reg >> 2;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // weighted mix and divide by 100
    always_ff @(posedge aclk) begin
        if (cmd_i.mix) begin
            mix_reg <= MIX_W'(res_reg[0][ROOT_W-1:0]) * WEIGHT_RED +
                       MIX_W'(res_reg[1][ROOT_W-1:0]) * WEIGHT_GREEN +
                       MIX_W'(res_reg[2][ROOT_W-1:0]) * WEIGHT_BLUE;
        end
        if (cmd_i.scale) begin
            prod_reg <= PROD_W'(mix_reg) * PROD_W'(RECIP);
        end
        if (cmd_i.zero) begin
            result_reg <= '0;
        end else if (cmd_i.quot) begin
            result_reg <= prod_reg[RECIP_SHIFT +: GRAY_W];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd_i.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.emit) begin
            m_gray_reg <= result_reg;
            m_last_reg <= last_pos;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_gray  = m_gray_reg;
    assign m_last  = m_last_reg;

    // status to the controller
    assign sts_o.input_done = in_row_reg >= h_eff;
    assign sts_o.due        = due_reg;
    assign sts_o.border     = (out_row_reg == RW'(0)) || (out_col_reg == CW'(0)) ||
                              out_row_last || out_col_last;
    assign sts_o.root_last  = step_reg == STEP_W'(ROOT_STEPS - 1);
    assign sts_o.out_free   = !m_valid_reg || m_ready;

    // input rows never run past the image
    assert property (@(posedge aclk) disable iff (!aresetn) in_row_reg <= h_eff)
        else $error("input row beyond image height");

    // output position wraps after the last pixel
    assert property (@(posedge aclk) disable iff (!aresetn) out_row_reg < h_eff)
        else $error("output row beyond image height");

endmodule

FILE: rtl/core/sobel_rgb_edge_to_gray.sv
// Sobel edge magnitude of an RGB pixel stream reduced to one gray value.
// Pixels enter in raster order; an edge result passes the window shift,
// gradients, squares, the 11-step iterative square root (one per channel),
// mix, scale and quotient. A border zero goes from the shift to the output,
// a pixel with no result due ends after the shift, a drain after the frame
// goes straight to the output and a dropped flush ends at once; a result
// may wait for the output register to free up. Results lag the input by
// one row plus one pixel; after the frame, one transaction of any kind
// (flush set or not) drains each remaining result, and m_last marks the
// final pixel. Writing image_width or image_height restarts the frame.
module sobel_rgb_edge_to_gray import sobel_pkg::*; #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_red,
    input  logic [SAMPLE_BITS-1:0] s_green,
    input  logic [SAMPLE_BITS-1:0] s_blue,
    input  logic                   s_flush,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [GRAY_W-1:0]      m_gray,
    output logic                   m_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // configuration is always accepted
    assign cfg_ready = 1'b1;

    sobel_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_flush (s_flush),
        .s_ready (s_ready),
        .cmd_o   (cmd),
        .sts_i   (sts)
    );

    sobel_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_i     (cmd),
        .sts_o     (sts),
        .s_red     (s_red),
        .s_green   (s_green),
        .s_blue    (s_blue),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_gray    (m_gray),
        .m_last    (m_last)
    );

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import sobel_pkg::*;

    localparam int MAXW       = 1024;
    localparam int MAXH       = 1024;
    localparam int STALL_MAX  = 20000;
    localparam int SETTLE     = 40;
    localparam int ITEMS      = 1400;
    localparam int CALM_AFTER = 1300;

    // index that maps to no register
    localparam logic [CFG_INDEX_W-1:0] REG_NONE = 2'd2;

    typedef struct {
        logic                   pause;
        logic [SAMPLE_BITS-1:0] red;
        logic [SAMPLE_BITS-1:0] green;
        logic [SAMPLE_BITS-1:0] blue;
        logic                   flush;
    } pixel_item_t;

    typedef struct {
        logic [GRAY_W-1:0] gray;
        logic              last;
    } gray_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [SAMPLE_BITS-1:0] s_red;
    logic [SAMPLE_BITS-1:0] s_green;
    logic [SAMPLE_BITS-1:0] s_blue;
    logic                   s_flush;
    logic                   m_valid;
    logic                   m_ready;
    logic [GRAY_W-1:0]      m_gray;
    logic                   m_last;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sobel_rgb_edge_to_gray dut (.*);

    pixel_item_t  pixel_queue[$];
    gray_result_t gray_expected[$];
    int           error_count;
    int           items_queued;
    logic         calm;
    logic         hold_req;

    // predictor state
    logic [10:0]  model_width;
    logic [10:0]  model_height;
    pixel_t       line_mem[2*MAXW];
    pixel_t       win[9];
    int unsigned  col_in;
    int unsigned  row_in;
    int unsigned  pos_out;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void clear_frame();
        col_in = 0;
        row_in = 0;
        pos_out = 0;
        for (int i = 0; i < 9; i++) win[i] = '0;
    endfunction

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned res;
        int unsigned bitv;
        res = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic int unsigned edge_mag(int k);
        int s[9];
        int gx;
        int gy;
        for (int i = 0; i < 9; i++) s[i] = win[i][k];
        gx = (s[0] + 2*s[3] + s[6]) - (s[2] + 2*s[5] + s[8]);
        gy = (s[0] + 2*s[1] + s[2]) - (s[6] + 2*s[7] + s[8]);
        return int_sqrt(gx*gx + gy*gy);
    endfunction

    // register write as seen by the predictor
    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        if (idx == REG_IMAGE_WIDTH) model_width = d;
        else if (idx == REG_IMAGE_HEIGHT) model_height = d;
        else return;
        clear_frame();
    endfunction

    // one accepted input transaction: update state, queue any gray result
    function automatic void predict_gray(pixel_t px, logic fl);
        int unsigned  w;
        int unsigned  h;
        int unsigned  n;
        int unsigned  c;
        int unsigned  slot_old;
        int unsigned  slot_prev;
        int unsigned  pr;
        int unsigned  pc;
        int unsigned  mix;
        logic         done;
        gray_result_t r;
        pixel_t       top;
        pixel_t       mid;
        w = clamp_dim(model_width, MAXW);
        h = clamp_dim(model_height, MAXH);
        done = row_in >= h;
        if (!done) begin
            if (fl) return;
            c = col_in % MAXW;
            slot_old = (row_in & 1) * MAXW + c;
            slot_prev = ((row_in + 1) & 1) * MAXW + c;
            top = line_mem[slot_old];
            mid = line_mem[slot_prev];
            line_mem[slot_old] = px;
            win[0] = win[1]; win[1] = win[2]; win[2] = top;
            win[3] = win[4]; win[4] = win[5]; win[5] = mid;
            win[6] = win[7]; win[7] = win[8]; win[8] = px;
            n = row_in * w + col_in;
            col_in++;
            if (col_in >= w) begin
                col_in = 0;
                row_in++;
            end
            if (n < w + 1) return;
        end
        pr = pos_out / w;
        pc = pos_out % w;
        r.gray = '0;
        if (!(pr == 0 || pc == 0 || pr == h - 1 || pc == w - 1) && !done) begin
            mix = 30*edge_mag(0) + 59*edge_mag(1) + 11*edge_mag(2);
            mix = mix / 100;
            if (mix > 2047) mix = 2047;
            r.gray = mix[GRAY_W-1:0];
        end
        r.last = (pos_out + 1 >= w * h);
        gray_expected.push_back(r);
        if (r.last) clear_frame();
        else pos_out++;
    endfunction

    // check results, then track register writes and inputs
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (gray_expected.size() == 0) begin
                    $error("unexpected result gray=%0d last=%0d", m_gray, m_last);
                    error_count++;
                end else begin
                    if (m_gray !== gray_expected[0].gray) begin
                        $error("gray expected %0d actual %0d", gray_expected[0].gray, m_gray);
                        error_count++;
                    end
                    if (m_last !== gray_expected[0].last) begin
                        $error("last expected %0d actual %0d", gray_expected[0].last, m_last);
                        error_count++;
                    end
                    void'(gray_expected.pop_front());
                end
            end
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) predict_gray({s_blue, s_green, s_red}, s_flush);
        end
    end

    // input driver
    int tx_idle;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_red   <= '0;
            s_green <= '0;
            s_blue  <= '0;
            s_flush <= 1'b0;
            tx_idle <= 0;
        end else if (!(s_valid && !s_ready)) begin
            if (tx_idle > 0) begin
                s_valid <= 1'b0;
                tx_idle <= tx_idle - 1;
            end else if (pixel_queue.size() > 0 && pixel_queue[0].pause) begin
                // sender waits until every pending result is out
                s_valid <= 1'b0;
                if (!s_valid && gray_expected.size() == 0) void'(pixel_queue.pop_front());
            end else if (pixel_queue.size() > 0) begin
                s_valid <= 1'b1;
                s_red   <= pixel_queue[0].red;
                s_green <= pixel_queue[0].green;
                s_blue  <= pixel_queue[0].blue;
                s_flush <= pixel_queue[0].flush;
                void'(pixel_queue.pop_front());
                if (!calm && $urandom_range(0, 9) == 0) tx_idle <= $urandom_range(1, 8);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    int rx_idle;
    int rx_hold;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_idle <= 0;
            rx_hold <= 0;
        end else if (hold_req) begin
            m_ready <= 1'b0;
            rx_hold <= 400;
        end else if (rx_hold > 0) begin
            m_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end else if (rx_idle > 0) begin
            m_ready <= 1'b0;
            rx_idle <= rx_idle - 1;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) rx_idle <= $urandom_range(1, 8);
        end
    end

    // watchdog on cycles without any transaction
    int quiet_cycles;
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return SAMPLE_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_byte();
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic void push_item(logic fl, logic [SAMPLE_BITS-1:0] r,
                                      logic [SAMPLE_BITS-1:0] g, logic [SAMPLE_BITS-1:0] b);
        pixel_item_t it;
        it.pause = 1'b0;
        it.flush = fl;
        it.red = r;
        it.green = g;
        it.blue = b;
        pixel_queue.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_pause();
        pixel_item_t it;
        it = '{1'b1, '0, '0, '0, 1'b0};
        pixel_queue.push_back(it);
    endfunction

    // a whole frame plus the drain transactions, or npix pixels; noise adds stray flushes
    function automatic void push_frame(logic [10:0] w_reg, logic [10:0] h_reg, int noise,
                                       int npix);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned drains;
        w = clamp_dim(w_reg, MAXW);
        h = clamp_dim(h_reg, MAXH);
        total = w * h;
        if (npix >= 0 && npix < total) total = npix;
        for (int i = 0; i < total; i++) begin
            if (noise > 0 && $urandom_range(0, 99) < noise)
                push_item(1'b1, rand_byte(), rand_byte(), rand_byte());
            push_item(1'b0, rand_sample(), rand_sample(), rand_sample());
        end
        if (npix >= 0) return;
        drains = (total < w + 1) ? total : w + 1;
        for (int i = 0; i < drains; i++)
            push_item($urandom_range(0, 9) < 7, rand_byte(), rand_byte(), rand_byte());
    endfunction

    task automatic wait_quiet();
        while (pixel_queue.size() > 0 || s_valid || gray_expected.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_size(logic [10:0] w, logic [10:0] h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    initial begin
        logic [10:0] rw;
        logic [10:0] rh;
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        calm = 1'b0;
        error_count = 0;
        items_queued = 0;
        model_width = WIDTH_RESET;
        model_height = HEIGHT_RESET;
        for (int i = 0; i < 2*MAXW; i++) line_mem[i] = '0;
        clear_frame();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: 4x4 checkerboard of extremes, a stray flush, drains
        set_size(11'd4, 11'd4);
        for (int i = 0; i < 16; i++) begin
            if (i == 6) push_item(1'b1, '1, '1, '1);
            if ((i + i/4) % 2 == 0) push_item(1'b0, '1, '1, '1);
            else push_item(1'b0, '0, '0, '0);
        end
        for (int i = 0; i < 5; i++) push_item(i == 2 ? 1'b0 : 1'b1, '1, '0, '1);
        wait_quiet();

        // long receiver hold-off while the sender keeps offering
        set_size(11'd10, 11'd6);
        push_frame(11'd10, 11'd6, 0, -1);
        @(posedge aclk);
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        wait_quiet();

        // sender pause mid-frame until all results are out
        set_size(11'd7, 11'd5);
        push_frame(11'd7, 11'd5, 0, 20);
        push_pause();
        push_frame(11'd7, 11'd5, 0, 15);
        for (int i = 0; i < 8; i++) push_item(1'b1, '0, '0, '0);
        wait_quiet();

        // size extremes, zero and oversized values
        set_size(11'd0, 11'd0);
        push_frame(11'd0, 11'd0, 0, -1);
        push_frame(11'd0, 11'd0, 0, -1);
        wait_quiet();
        set_size(11'd1, 11'd2047);
        push_frame(11'd1, 11'd2047, 0, -1);
        wait_quiet();
        set_size(11'd2047, 11'd1);
        push_frame(11'd2047, 11'd1, 0, 40);
        wait_quiet();

        // unused register index mid-frame, then a frame broken off by a register write
        set_size(11'd6, 11'd6);
        push_frame(11'd6, 11'd6, 5, 22);
        wait_quiet();
        write_reg(REG_NONE, 11'h7ff);
        push_frame(11'd6, 11'd6, 0, 6);
        wait_quiet();
        write_reg(REG_IMAGE_HEIGHT, 11'd5);
        push_frame(11'd6, 11'd5, 0, -1);
        wait_quiet();

        // random frames, mostly small
        rw = 11'd6;
        rh = 11'd5;
        while (items_queued < ITEMS) begin
            if (items_queued > CALM_AFTER) calm = 1'b1;
            case ($urandom_range(0, 5))
                0: begin
                    rw = 11'($urandom_range(1, 12));
                    write_reg(REG_IMAGE_WIDTH, rw);
                end
                1: begin
                    rh = 11'($urandom_range(1, 8));
                    write_reg(REG_IMAGE_HEIGHT, rh);
                end
                2: ;
                default: begin
                    rw = 11'($urandom_range(1, 12));
                    rh = 11'($urandom_range(1, 8));
                    set_size(rw, rh);
                end
            endcase
            if ($urandom_range(0, 7) == 0) begin
                push_frame(rw, rh, 5, $urandom_range(0, 20));
            end else begin
                push_frame(rw, rh, 5, -1);
                if ($urandom_range(0, 3) == 0) push_frame(rw, rh, 0, -1);
            end
            wait_quiet();
        end

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // errors flagged by $error are counted at the check sites
endmodule
